// ----- src/cnmf_pkg.sv -----
package cnmf_pkg;

  localparam int CH_W   = 8;
  localparam int CFG_W  = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // A sum of up to five channel values, and the count of terms in it.
  localparam int SUM_W  = CH_W + 3;
  localparam int CNT_W  = 3;

  // Exact floor division of a SUM_W-bit value by three and by five:
  // multiply by the rounded-up reciprocal and drop the low bits.
  localparam int K3       = SUM_W + 2;
  localparam int K5       = SUM_W + 3;
  localparam int RECIP3   = (2 ** K3 + 2) / 3;
  localparam int RECIP5   = (2 ** K5 + 4) / 5;
  localparam int RECIP_W  = K5 - 2;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            frame_done;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  // Neighbourhood as read from the line stores for one pending pixel.
  typedef struct packed {
    rgba_t centre;
    rgb_t  left;
    rgb_t  right;
    rgb_t  above;
  } nbhd_t;

  typedef struct packed {
    logic left;
    logic right;
    logic below;
    logic above;
  } nb_use_t;

  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } lane_ctl_t;

  function automatic rgb_t rgb_of(input rgba_t px);
    rgb_t res;
    res.red   = px.red;
    res.green = px.green;
    res.blue  = px.blue;
    return res;
  endfunction

endpackage

// ----- src/cnmf_lane.sv -----
module cnmf_lane (
  input  logic                    clk_i,
  input  cnmf_pkg::lane_ctl_t     ctl_i,
  input  cnmf_pkg::nb_use_t       use_i,
  input  logic [cnmf_pkg::CH_W-1:0] centre_i,
  input  logic [cnmf_pkg::CH_W-1:0] left_i,
  input  logic [cnmf_pkg::CH_W-1:0] right_i,
  input  logic [cnmf_pkg::CH_W-1:0] below_i,
  input  logic [cnmf_pkg::CH_W-1:0] above_i,
  output logic [cnmf_pkg::CH_W-1:0] mean_o
);
  import cnmf_pkg::*;

  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_q;

  always_comb begin
    sum_d = SUM_W'(centre_i)
          + (use_i.left  ? SUM_W'(left_i)  : '0)
          + (use_i.right ? SUM_W'(right_i) : '0)
          + (use_i.below ? SUM_W'(below_i) : '0)
          + (use_i.above ? SUM_W'(above_i) : '0);
    cnt_d = CNT_W'(1) + CNT_W'(use_i.left) + CNT_W'(use_i.right)
          + CNT_W'(use_i.below) + CNT_W'(use_i.above);
  end

  assign recip = (cnt_q == CNT_W'(5)) ? RECIP_W'(RECIP5) : RECIP_W'(RECIP3);

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (ctl_i.mul_en) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(recip);
    end
  end

  // Powers of two shift; three and five come from the registered product.
  always_comb begin
    case (cnt_q)
      CNT_W'(1): mean_o = sum_q[CH_W-1:0];
      CNT_W'(2): mean_o = sum_q[CH_W:1];
      CNT_W'(3): mean_o = prod_q[K3 +: CH_W];
      CNT_W'(4): mean_o = sum_q[CH_W+1:2];
      CNT_W'(5): mean_o = prod_q[K5 +: CH_W];
      default:   mean_o = '0;
    endcase
  end

endmodule

// ----- src/cnmf_line_store.sv -----
module cnmf_line_store #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic                 clk_i,
  input  logic [COL_W-1:0]     rd_col_i,
  input  logic [COL_W-1:0]     rd_left_i,
  input  logic [COL_W-1:0]     rd_right_i,
  input  logic [COL_W-1:0]     wr_addr_i,
  input  logic                 above_we_i,
  input  cnmf_pkg::rgb_t       above_wdata_i,
  input  logic                 cur_we_i,
  input  cnmf_pkg::rgba_t      cur_wdata_i,
  output cnmf_pkg::nbhd_t      nbhd_o
);
  import cnmf_pkg::*;

  // The above store holds the row above the pending row ahead of the current
  // column, and the pending row itself behind it.
  rgb_t  above_mem [MAX_WIDTH];
  rgba_t cur_mem   [MAX_WIDTH];

  rgb_t  above_rd_q, left_rd_q, right_rd_q;
  rgba_t centre_rd_q;

  always_ff @(posedge clk_i) begin
    if (above_we_i) begin
      above_mem[wr_addr_i] <= above_wdata_i;
    end
    if (cur_we_i) begin
      cur_mem[wr_addr_i] <= cur_wdata_i;
    end
    above_rd_q  <= above_mem[rd_col_i];
    left_rd_q   <= above_mem[rd_left_i];
    centre_rd_q <= cur_mem[rd_col_i];
    right_rd_q  <= rgb_of(cur_mem[rd_right_i]);
  end

  always_comb begin
    nbhd_o.centre = centre_rd_q;
    nbhd_o.left   = left_rd_q;
    nbhd_o.right  = right_rd_q;
    nbhd_o.above  = above_rd_q;
  end

endmodule

// ----- src/cross_neighborhood_mean_filter_unit.sv -----
// An item that releases a result steps through ST_READ (registered line store read), ST_SUM
// (lane adder), ST_MUL (lane reciprocal multiplier) and ST_EMIT, which registers the result on
// out_valid_o; the input is closed until idle again. A first-row pixel or a drain with nothing
// pending is taken without leaving idle. A stalled output holds the sequencer in its last step.
// Reset (rst_ni low, asynchronous) clears the sequencer, column, row count and output valid,
// and sets the width to 1024; the line stores are not cleared.
module cross_neighborhood_mean_filter_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cnmf_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cnmf_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cnmf_pkg::CFG_W-1:0]      cfg_data_i
);
  import cnmf_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  localparam logic [1:0] ROWS_NONE = 2'd0;
  localparam logic [1:0] ROWS_MANY = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] width_q;
  logic [COL_W-1:0] col_pos_q, col_pos_d;
  logic [1:0]       rows_q, rows_d;

  in_item_t         item_q;
  logic [COL_W-1:0] col_q, left_addr_q, right_addr_q;
  logic             last_q;
  nb_use_t          use_q;

  logic             out_valid_q;
  out_item_t        out_q;

  logic [WID_W-1:0] w_eff, w_last;
  logic [COL_W-1:0] col_cur;
  logic             is_last, is_drain, emits, accept;
  logic             out_free, emit_fire, store_only;
  logic [COL_W-1:0] step_col;
  logic             step_last, step_drain, advance;

  nbhd_t            nbhd;
  lane_ctl_t        lane_ctl;
  logic [CH_W-1:0]  mean_red, mean_green, mean_blue;
  logic             cur_we;
  rgba_t            cur_wdata;
  logic [COL_W-1:0] wr_addr;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_q);
    end
    w_last = w_eff - WID_W'(1);
    // A column left beyond a narrowed row is taken as its last column.
    if (WID_W'(col_pos_q) >= w_eff) begin
      col_cur = w_last[COL_W-1:0];
    end else begin
      col_cur = col_pos_q;
    end
    is_last = (WID_W'(col_cur) == w_last);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign is_drain    = (in_data_i.opcode == OP_DRAIN);
  assign emits       = (rows_q != ROWS_NONE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_fire   = (state_q == ST_EMIT) && out_free;
  assign store_only  = accept && !emits && !is_drain;
  assign advance     = store_only || emit_fire;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && emits) state_d = ST_READ;
      ST_READ: state_d = ST_SUM;
      ST_SUM:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step_col   = emit_fire ? col_q : col_cur;
    step_last  = emit_fire ? last_q : is_last;
    step_drain = emit_fire && (item_q.opcode == OP_DRAIN);
    col_pos_d  = col_pos_q;
    rows_d     = rows_q;
    if (advance) begin
      if (step_last) begin
        col_pos_d = '0;
        if (step_drain) begin
          rows_d = ROWS_NONE;
        end else if (rows_q != ROWS_MANY) begin
          rows_d = rows_q + 2'd1;
        end
      end else begin
        col_pos_d = step_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= CFG_RESET;
      col_pos_q <= '0;
      rows_q    <= ROWS_NONE;
    end else begin
      state_q   <= state_d;
      col_pos_q <= col_pos_d;
      rows_q    <= rows_d;
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emits) begin
      item_q       <= in_data_i;
      col_q        <= col_cur;
      last_q       <= is_last;
      left_addr_q  <= (col_cur == '0) ? col_cur : col_cur - COL_W'(1);
      right_addr_q <= is_last ? col_cur : col_cur + COL_W'(1);
      use_q.left   <= (col_cur != '0);
      use_q.right  <= !is_last;
      use_q.below  <= !is_drain;
      use_q.above  <= (rows_q == ROWS_MANY);
    end
  end

  // The pending pixel moves into the above store as its result leaves; the new pixel, if the item
  // is one, takes its place in the current store. A first-row pixel is written there directly.
  always_comb begin
    wr_addr         = emit_fire ? col_q : col_cur;
    cur_we          = store_only || (emit_fire && (item_q.opcode == OP_PIXEL));
    cur_wdata.red   = emit_fire ? item_q.in_red   : in_data_i.in_red;
    cur_wdata.green = emit_fire ? item_q.in_green : in_data_i.in_green;
    cur_wdata.blue  = emit_fire ? item_q.in_blue  : in_data_i.in_blue;
    cur_wdata.alpha = emit_fire ? item_q.in_alpha : in_data_i.in_alpha;
  end

  cnmf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_line_store (
    .clk_i         (clk_i),
    .rd_col_i      (col_q),
    .rd_left_i     (left_addr_q),
    .rd_right_i    (right_addr_q),
    .wr_addr_i     (wr_addr),
    .above_we_i    (emit_fire),
    .above_wdata_i (rgb_of(nbhd.centre)),
    .cur_we_i      (cur_we),
    .cur_wdata_i   (cur_wdata),
    .nbhd_o        (nbhd)
  );

  always_comb begin
    lane_ctl.sum_en = (state_q == ST_SUM);
    lane_ctl.mul_en = (state_q == ST_MUL);
  end

  cnmf_lane u_lane_red (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .use_i    (use_q),
    .centre_i (nbhd.centre.red),
    .left_i   (nbhd.left.red),
    .right_i  (nbhd.right.red),
    .below_i  (item_q.in_red),
    .above_i  (nbhd.above.red),
    .mean_o   (mean_red)
  );

  cnmf_lane u_lane_green (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .use_i    (use_q),
    .centre_i (nbhd.centre.green),
    .left_i   (nbhd.left.green),
    .right_i  (nbhd.right.green),
    .below_i  (item_q.in_green),
    .above_i  (nbhd.above.green),
    .mean_o   (mean_green)
  );

  cnmf_lane u_lane_blue (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .use_i    (use_q),
    .centre_i (nbhd.centre.blue),
    .left_i   (nbhd.left.blue),
    .right_i  (nbhd.right.blue),
    .below_i  (item_q.in_blue),
    .above_i  (nbhd.above.blue),
    .mean_o   (mean_blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.out_red    <= mean_red;
      out_q.out_green  <= mean_green;
      out_q.out_blue   <= mean_blue;
      out_q.out_alpha  <= nbhd.centre.alpha;
      out_q.frame_done <= (item_q.opcode == OP_DRAIN) && last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/cnmf_checker.sv -----
module cnmf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cnmf_pkg::out_item_t out_data_o
);

  // A result waiting on the output keeps its beat unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed or vanished while stalled");

  // An item that releases a result keeps the input closed through its read, sum, multiply and emit steps.
  a_busy_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input reopened before the result was formed");

  // A fresh result follows its accepted item after a fixed delay.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 5) && $past(!in_ready_o))
    else $error("result appeared without a matching accepted item");

endmodule

bind cross_neighborhood_mean_filter_unit cnmf_checker u_cnmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- dv/tb.sv -----
module tb;
  import cnmf_pkg::*;

  localparam int          MAX_W         = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned RANDOM_ITEMS  = 560;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // Own copy of the filter state, advanced once per accepted input beat.
  rgb_t             row_above   [MAX_W];
  rgba_t            row_pending [MAX_W];
  int unsigned      col_pos     = 0;
  int unsigned      rows_done   = 0;
  logic [CFG_W-1:0] width_reg   = CFG_RESET;

  out_item_t        means_due [$];
  int unsigned      fail_count  = 0;
  int unsigned      live_items  = 0;
  int unsigned      cycle_count = 0;
  bit               calm        = 1'b0;
  bit               hold_off_req = 1'b0;

  cross_neighborhood_mean_filter_unit #(
    .MAX_WIDTH (MAX_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [CH_W-1:0] draw_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t draw_item(input logic op);
    in_item_t item;
    item.opcode   = op;
    item.in_red   = draw_channel();
    item.in_green = draw_channel();
    item.in_blue  = draw_channel();
    item.in_alpha = draw_channel();
    return item;
  endfunction

  function automatic in_item_t pixel(input int unsigned r, g, b, a);
    in_item_t item;
    item.opcode   = OP_PIXEL;
    item.in_red   = CH_W'(r);
    item.in_green = CH_W'(g);
    item.in_blue  = CH_W'(b);
    item.in_alpha = CH_W'(a);
    return item;
  endfunction

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  // Mean over the pending pixel at column c and whichever neighbours exist; the
  // pending pixel then moves into the row above.
  function automatic void release_mean(input int unsigned c, input int unsigned w,
                                       input bit has_below, input rgb_t below,
                                       input bit closes);
    int unsigned sum_r, sum_g, sum_b, terms;
    out_item_t   res;
    sum_r = 32'(row_pending[c].red);
    sum_g = 32'(row_pending[c].green);
    sum_b = 32'(row_pending[c].blue);
    terms = 1;
    if (c > 0) begin
      sum_r += row_above[c-1].red;
      sum_g += row_above[c-1].green;
      sum_b += row_above[c-1].blue;
      terms++;
    end
    if (c + 1 < w) begin
      sum_r += row_pending[c+1].red;
      sum_g += row_pending[c+1].green;
      sum_b += row_pending[c+1].blue;
      terms++;
    end
    if (has_below) begin
      sum_r += below.red;
      sum_g += below.green;
      sum_b += below.blue;
      terms++;
    end
    if (rows_done >= 2) begin
      sum_r += row_above[c].red;
      sum_g += row_above[c].green;
      sum_b += row_above[c].blue;
      terms++;
    end
    res.out_red    = CH_W'(sum_r / terms);
    res.out_green  = CH_W'(sum_g / terms);
    res.out_blue   = CH_W'(sum_b / terms);
    res.out_alpha  = row_pending[c].alpha;
    res.frame_done = closes;
    means_due.push_back(res);
    row_above[c].red   = row_pending[c].red;
    row_above[c].green = row_pending[c].green;
    row_above[c].blue  = row_pending[c].blue;
  endfunction

  // Returns 0 for a drain that the block ignores.
  function automatic bit filter_item(input in_item_t item);
    int unsigned w, c;
    bit          at_end;
    rgb_t        below;
    w = active_width();
    c = (col_pos >= w) ? w - 1 : col_pos;
    at_end = (c + 1 >= w);
    if (item.opcode == OP_PIXEL) begin
      below.red   = item.in_red;
      below.green = item.in_green;
      below.blue  = item.in_blue;
      if (rows_done != 0) release_mean(c, w, 1'b1, below, 1'b0);
      row_pending[c].red   = item.in_red;
      row_pending[c].green = item.in_green;
      row_pending[c].blue  = item.in_blue;
      row_pending[c].alpha = item.in_alpha;
      if (at_end) begin
        col_pos = 0;
        if (rows_done < 2) rows_done++;
      end else begin
        col_pos = c + 1;
      end
      return 1'b1;
    end
    if (rows_done == 0) return 1'b0;
    release_mean(c, w, 1'b0, '0, at_end);
    if (at_end) begin
      col_pos   = 0;
      rows_done = 0;
    end else begin
      col_pos = c + 1;
    end
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (filter_item(item)) live_items++;
  endtask

  // A first-row pixel gives no result, so the wait after the queue empties
  // covers any beat still inside the block.
  task automatic set_width(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (means_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    width_reg = value;
  endtask

  task automatic close_frame();
    while (rows_done == 0 && col_pos != 0) send_item(draw_item(OP_PIXEL));
    while (rows_done != 0) send_item(draw_item(OP_DRAIN));
  endtask

  task automatic test_drains_and_width_cut();
    send_item(draw_item(OP_DRAIN));
    send_item(pixel(0, 0, 0, 0));
    send_item(pixel(255, 255, 255, 255));
    send_item(pixel(255, 0, 255, 0));
    send_item(draw_item(OP_DRAIN));
    // Narrowing below the current column makes the next pixel end the row.
    set_width(3);
    send_item(pixel(0, 255, 0, 255));
    send_item(pixel(255, 255, 255, 1));
    send_item(pixel(0, 0, 0, 128));
    send_item(pixel(255, 255, 255, 254));
    send_item(pixel(17, 34, 51, 68));
    send_item(draw_item(OP_DRAIN));
    send_item(draw_item(OP_DRAIN));
  endtask

  task automatic test_width_limits();
    // A width of zero behaves as one, so every pixel is a row of its own.
    set_width(0);
    send_item(pixel(255, 0, 255, 0));
    send_item(pixel(0, 255, 0, 255));
    send_item(pixel(128, 127, 1, 200));
    send_item(draw_item(OP_DRAIN));
    set_width(1);
    send_item(pixel(255, 255, 255, 255));
    send_item(pixel(254, 253, 252, 251));
    send_item(draw_item(OP_DRAIN));
  endtask

  task automatic test_widest_rows();
    set_width('1);
    repeat (MAX_W) send_item(draw_item(OP_PIXEL));
    // Only the first few columns of the stored row are drained to end the frame.
    set_width(4);
    close_frame();
  endtask

  task automatic test_output_hold_off();
    set_width(6);
    calm = 1'b1;
    repeat (6) send_item(draw_item(OP_PIXEL));
    hold_off_req = 1'b1;
    repeat (18) send_item(draw_item(OP_PIXEL));
    calm = 1'b0;
    close_frame();
  endtask

  task automatic test_random_frames();
    int unsigned w, rows, count, cut_at;
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0:          w = 0;
        1, 2, 3, 4: w = $urandom_range(9, 40);
        5:          w = $urandom_range(41, 160);
        default:    w = $urandom_range(1, 8);
      endcase
      set_width(CFG_W'(w));
      rows   = $urandom_range(1, 6);
      count  = rows * ((w == 0) ? 1 : w);
      cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count - 1) : count;
      for (int unsigned k = 0; k < count; k++) begin
        // Never widened inside a frame, so no unwritten column is read.
        if (k == cut_at) set_width(CFG_W'($urandom_range(0, active_width())));
        if ($urandom_range(0, 24) == 0) send_item(draw_item(OP_DRAIN));
        send_item(draw_item(OP_PIXEL));
      end
      close_frame();
    end
    calm = 1'b0;
  endtask

  initial begin : result_pacer
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        span = draw_gap();
        if (span != 0) begin
          out_ready_i <= 1'b0;
          repeat (span) @(posedge clk_i);
        end
      end
    end
  end

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= 30) $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (means_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 30) $error("result beat with no pending expectation");
      end else begin
        want = means_due.pop_front();
        if (out_data_o.out_red !== want.out_red)
          report("out_red", 32'(want.out_red), 32'(out_data_o.out_red));
        if (out_data_o.out_green !== want.out_green)
          report("out_green", 32'(want.out_green), 32'(out_data_o.out_green));
        if (out_data_o.out_blue !== want.out_blue)
          report("out_blue", 32'(want.out_blue), 32'(out_data_o.out_blue));
        if (out_data_o.out_alpha !== want.out_alpha)
          report("out_alpha", 32'(want.out_alpha), 32'(out_data_o.out_alpha));
        if (out_data_o.frame_done !== want.frame_done)
          report("frame_done", 32'(want.frame_done), 32'(out_data_o.frame_done));
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_drains_and_width_cut();
    test_width_limits();
    test_widest_rows();
    test_output_hold_off();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (means_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- cross_neighborhood_mean_filter_unit.f -----
src/cnmf_pkg.sv
src/cnmf_lane.sv
src/cnmf_line_store.sv
src/cross_neighborhood_mean_filter_unit.sv
src/cnmf_checker.sv
dv/tb.sv
